/* hw/rtl/dsm_pkg.sv */
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared constants for the decimal string multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package dsm_pkg;

   localparam int MaxDigits = 32;

   // acc / 10 == (acc * Recip10) >> RecipShift for every acc below 16384
   localparam int Recip10    = 6554;
   localparam int RecipShift = 16;

   localparam logic [3:0] MaxDecDigit = 4'd9;

   localparam logic KindFirst  = 1'b0;
   localparam logic KindSecond = 1'b1;

endpackage

`default_nettype wire

/* hw/rtl/dsm_operand_store.sv */
// ----------------------------------------------------------------------------
// dsm_operand_store
// Digit memory for one operand, MSB first, with length and completion flags.
// ----------------------------------------------------------------------------
`default_nettype none

module dsm_operand_store
   import dsm_pkg::*;
#(
   parameter int MAX_DIGITS = MaxDigits,
   localparam int LenW  = $clog2(MAX_DIGITS + 1),
   localparam int AddrW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [3:0]       wr_digit,
   input  wire logic             wr_last,
   input  wire logic             clear,
   output logic      [LenW-1:0]  len,
   output logic                  complete,
   output logic                  drop,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [3:0]       rd_data
);

   logic [3:0]      mem_ff [MAX_DIGITS];
   logic [3:0]      rd_data_ff;
   logic [LenW-1:0] len_ff;
   logic            complete_ff;
   logic            take;
   logic            room;

   assign take = wr_en && !complete_ff;
   assign room = len_ff < LenW'(MAX_DIGITS);
   assign drop = take && !room;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         complete_ff <= 1'b0;
      end else if (clear) begin
         len_ff      <= '0;
         complete_ff <= 1'b0;
      end else if (take) begin
         if (room) begin
            len_ff <= len_ff + LenW'(1);
         end
         if (wr_last) begin
            complete_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && room) begin
         mem_ff[len_ff[AddrW-1:0]] <= wr_digit;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign len      = len_ff;
   assign complete = complete_ff;
   assign rd_data  = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/dsm_engine.sv */
// ----------------------------------------------------------------------------
// dsm_engine
// Column-by-column decimal multiply: one digit product per term, carry
// split with a reciprocal multiply, product digits stored LSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module dsm_engine
   import dsm_pkg::*;
#(
   parameter int MAX_DIGITS = MaxDigits,
   localparam int LenW  = $clog2(MAX_DIGITS + 1),
   localparam int AddrW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
   localparam int PosW  = $clog2(2 * MAX_DIGITS),
   localparam int SumW  = PosW + 1,
   localparam int AccW  = $clog2(MAX_DIGITS * 90 + 1),
   localparam int MulW  = AccW + RecipShift
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [LenW-1:0]  len_a,
   input  wire logic [LenW-1:0]  len_b,
   output logic      [AddrW-1:0] a_addr,
   input  wire logic [3:0]       a_data,
   output logic      [AddrW-1:0] b_addr,
   input  wire logic [3:0]       b_data,
   input  wire logic [PosW-1:0]  rd_addr,
   output logic      [3:0]       rd_data,
   output logic                  done,
   output logic      [PosW-1:0]  top_pos
);

   typedef enum logic [2:0] {
      EN_IDLE, EN_COL, EN_FETCH, EN_MAC, EN_DIV, EN_WRITE
   } eng_state_type;

   eng_state_type   state_ff;
   logic [PosW-1:0] p_ff;
   logic [AddrW-1:0] a_ff;
   logic [AccW-1:0] acc_ff;
   logic [AccW-1:0] q_ff;
   logic [PosW-1:0] nz_ff;
   logic            done_ff;
   logic [3:0]      pmem_ff [2 * MAX_DIGITS];
   logic [3:0]      rd_data_ff;

   logic [SumW-1:0] p_w, la_w, lb_w, a_w;
   logic [SumW-1:0] a_lo, a_hi, a_idx, b_idx;
   logic            has_terms;
   logic            last_col;
   logic [7:0]      term;
   logic [MulW-1:0] qmul;
   logic [AccW-1:0] rem;
   logic [3:0]      digit;

   assign p_w  = SumW'(p_ff);
   assign la_w = SumW'(len_a);
   assign lb_w = SumW'(len_b);
   assign a_w  = SumW'(a_ff);

   // range of first-operand weights that land in column p
   assign a_lo      = (p_w >= lb_w) ? (p_w - lb_w + SumW'(1)) : '0;
   assign a_hi      = (p_w < la_w) ? p_w : (la_w - SumW'(1));
   assign has_terms = a_lo <= a_hi;
   assign last_col  = p_w == (la_w + lb_w - SumW'(1));

   // stores are MSB first, weights count from the LSB
   assign a_idx  = la_w - SumW'(1) - a_w;
   assign b_idx  = lb_w + a_w - p_w - SumW'(1);
   assign a_addr = a_idx[AddrW-1:0];
   assign b_addr = b_idx[AddrW-1:0];

   assign term  = a_data * b_data;
   assign qmul  = MulW'(acc_ff) * MulW'(Recip10);
   assign rem   = acc_ff - (q_ff << 3) - (q_ff << 1);
   assign digit = rem[3:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EN_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            EN_IDLE: begin
               if (start) begin
                  p_ff     <= '0;
                  acc_ff   <= '0;
                  nz_ff    <= '0;
                  state_ff <= EN_COL;
               end
            end
            EN_COL: begin
               a_ff     <= a_lo[AddrW-1:0];
               state_ff <= has_terms ? EN_FETCH : EN_DIV;
            end
            EN_FETCH: begin
               state_ff <= EN_MAC;
            end
            EN_MAC: begin
               acc_ff <= acc_ff + AccW'(term);
               if (a_w == a_hi) begin
                  state_ff <= EN_DIV;
               end else begin
                  a_ff     <= a_ff + AddrW'(1);
                  state_ff <= EN_FETCH;
               end
            end
            EN_DIV: begin
               q_ff     <= qmul[RecipShift +: AccW];
               state_ff <= EN_WRITE;
            end
            EN_WRITE: begin
               acc_ff <= q_ff;
               if (digit != 4'd0) begin
                  nz_ff <= p_ff;
               end
               if (last_col) begin
                  done_ff  <= 1'b1;
                  state_ff <= EN_IDLE;
               end else begin
                  p_ff     <= p_ff + PosW'(1);
                  state_ff <= EN_COL;
               end
            end
            default: begin
               state_ff <= EN_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == EN_WRITE) begin
         pmem_ff[p_ff] <= digit;
      end
      rd_data_ff <= pmem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign done    = done_ff;
   assign top_pos = nz_ff;

endmodule

`default_nettype wire

/* hw/rtl/decimal_string_multiplier.sv */
// Operand words load at one per cycle while req_ready is high. The multiply
// starts once both complete flags are set and start_ff is registered; each
// column runs a setup state, fetch and MAC per digit product, then divide
// and write. Each product word passes a read state before it is sent.
// Throughput: one operand pair at a time; no new word during multiply/output.
// Reset: synchronous, clears lengths, flags, overflow and all control state.
`default_nettype none

module decimal_string_multiplier
   import dsm_pkg::*;
#(
   parameter int MAX_DIGITS = MaxDigits
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_kind,
   input  wire logic [3:0] req_digit,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic      [3:0] rsp_product_digit,
   output logic            rsp_last_res,
   output logic            rsp_overflow
);

   localparam int LenW  = $clog2(MAX_DIGITS + 1);
   localparam int AddrW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int PosW  = $clog2(2 * MAX_DIGITS);

   typedef enum logic [1:0] {ST_LOAD, ST_CALC, ST_READ, ST_SEND} state_type;

   state_type       state_ff;
   logic            start_ff;
   logic            rsp_valid_ff;
   logic            ovf_ff;
   logic [PosW-1:0] k_ff;

   logic             accept;
   logic [3:0]       digit_sat;
   logic             op_clear;
   logic [LenW-1:0]  len_a, len_b;
   logic             comp_a, comp_b, drop_a, drop_b;
   logic [AddrW-1:0] a_addr, b_addr;
   logic [3:0]       a_data, b_data;
   logic [3:0]       prod_data;
   logic             eng_done;
   logic [PosW-1:0]  eng_top;

   assign accept    = req_valid && req_ready;
   assign digit_sat = (req_digit > MaxDecDigit) ? MaxDecDigit : req_digit;
   assign req_ready = (state_ff == ST_LOAD) && !(comp_a && comp_b);
   assign op_clear  = (state_ff == ST_SEND) && rsp_ready && (k_ff == '0);

   dsm_operand_store #(.MAX_DIGITS(MAX_DIGITS)) u_store_a (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept && (req_kind == KindFirst)),
      .wr_digit (digit_sat),
      .wr_last  (req_last),
      .clear    (op_clear),
      .len      (len_a),
      .complete (comp_a),
      .drop     (drop_a),
      .rd_addr  (a_addr),
      .rd_data  (a_data)
   );

   dsm_operand_store #(.MAX_DIGITS(MAX_DIGITS)) u_store_b (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept && (req_kind == KindSecond)),
      .wr_digit (digit_sat),
      .wr_last  (req_last),
      .clear    (op_clear),
      .len      (len_b),
      .complete (comp_b),
      .drop     (drop_b),
      .rd_addr  (b_addr),
      .rd_data  (b_data)
   );

   dsm_engine #(.MAX_DIGITS(MAX_DIGITS)) u_engine (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .len_a   (len_a),
      .len_b   (len_b),
      .a_addr  (a_addr),
      .a_data  (a_data),
      .b_addr  (b_addr),
      .b_data  (b_data),
      .rd_addr (k_ff),
      .rd_data (prod_data),
      .done    (eng_done),
      .top_pos (eng_top)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ovf_ff       <= 1'b0;
         k_ff         <= '0;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               start_ff <= 1'b0;
               if (drop_a || drop_b) begin
                  ovf_ff <= 1'b1;
               end
               if (comp_a && comp_b) begin
                  start_ff <= 1'b1;
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               start_ff <= 1'b0;
               if (eng_done) begin
                  // leading zeros skipped: start at the top nonzero digit
                  k_ff     <= eng_top;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_SEND;
            end
            ST_SEND: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (k_ff == '0) begin
                     ovf_ff   <= 1'b0;
                     state_ff <= ST_LOAD;
                  end else begin
                     k_ff     <= k_ff - PosW'(1);
                     state_ff <= ST_READ;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_digit = prod_data;
   assign rsp_last_res      = (k_ff == '0);
   assign rsp_overflow      = ovf_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while a product word is pending");

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      eng_done |-> (state_ff == ST_CALC))
      else $error("multiply finished outside the compute phase");

   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $stable(ovf_ff))
      else $error("overflow flag changed during product output");

   a_start_after_load: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (comp_a && comp_b))
      else $error("multiply started without both operands complete");

endmodule

`default_nettype wire
